### design/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared definitions for the CAN receive supervisor
// Command, status, state and ID codes, the supervisor state record, and
// the helpers that count error events against it.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] CMD_FRAME    = 2'd0;
  localparam logic [1:0] CMD_CTRL_ERR = 2'd1;
  localparam logic [1:0] CMD_TX_FAIL  = 2'd2;

  // Frame status codes
  localparam logic [1:0] FS_ACCEPTED = 2'd0;
  localparam logic [1:0] FS_IGNORED  = 2'd1;
  localparam logic [1:0] FS_CHECKSUM = 2'd2;
  localparam logic [1:0] FS_STUCK    = 2'd3;

  // Node state codes
  localparam logic [7:0] ST_OFF          = 8'h01;
  localparam logic [7:0] ST_EMERGENCY    = 8'h08;
  localparam logic [7:0] ST_MOTOR_ERR    = 8'h10;
  localparam logic [7:0] ST_CENTRAL_DOWN = 8'h20;
  localparam logic [7:0] ST_BROKEN       = 8'h40;

  // Frame identifiers
  localparam logic [10:0] ID_MOTOR_ERR = 11'h001;
  localparam logic [10:0] ID_EMERGENCY = 11'h002;
  localparam logic [10:0] ID_STATUS    = 11'h004;
  localparam logic [10:0] ID_LOCAL_A   = 11'h010;
  localparam logic [10:0] ID_LOCAL_B   = 11'h040;
  localparam logic [10:0] ID_HW        = 11'h7FF;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 1'd1;
  localparam logic [7:0] ERROR_LIMIT_RST = 8'd20;
  localparam logic [7:0] STUCK_LIMIT_RST = 8'd5;

  typedef struct packed {
    logic [7:0] node_state;
    logic [7:0] last_alive;
    logic [7:0] stuck_cnt;
    logic [7:0] central_cnt;
    logic [7:0] local_cnt;
    logic       bus_stopped;
  } sup_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Count one error event against an ID; hw marks a controller hardware error
  function automatic sup_t err_event(input sup_t s, input logic [10:0] id,
                                     input logic hw, input logic [7:0] limit);
    sup_t r;
    r = s;
    if (id == ID_LOCAL_A || id == ID_LOCAL_B) begin
      r.local_cnt = sat_inc(s.local_cnt);
      if (r.local_cnt >= limit) begin
        r.bus_stopped = 1'b1;
        r.node_state  = ST_BROKEN;
      end
    end else if (id == ID_STATUS) begin
      r.central_cnt = sat_inc(s.central_cnt);
      if (r.central_cnt >= limit) begin
        r.node_state = ST_CENTRAL_DOWN;
      end
    end else if (id == ID_HW && hw) begin
      r.bus_stopped = 1'b1;
      r.node_state  = ST_BROKEN;
    end
    return r;
  endfunction

endpackage

### design/can_rx_supervisor.sv
// ----------------------------------------------------------------------------
// can_rx_supervisor: CAN receive frame and error event supervisor
// Checks received frames (checksum, alive counter), tracks node state and
// error counts, and stops the bus on local errors at the limit or hw errors.
// ----------------------------------------------------------------------------
//
//  channel | direction | word                                   | handshake
//  --------+-----------+----------------------------------------+-------------
//  in_     | sink      | tuser kind, tdata frame/error fields   | tvalid/tready
//  out_    | source    | tdata state, status and request flags  | tvalid/tready
//  cfg_    | sink      | register index and value               | cfg_wr_en
//
// Each word passes from the input register through the update logic into
// the result register. The supervisor state updates at the edge that loads
// the result, so the next word sees it; one word per cycle is sustained
// while the output is not stalled. Reset clears the state, the valid flags
// and restores both limits. A stalled result holds the pipeline; an empty
// input register takes one more word while the result waits, then in_tready
// drops until the result drains.
//
module can_rx_supervisor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [10:0] frame_id, [11] extended_id, [15:12] length_code, [79:16] payload,
  // [80] bus_off_err, [81] ack_err, [82] fifo_overflow_err, [87:83] zero
  input  logic [87:0]                   in_tdata,
  // [1:0] command
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] node_state, [8] bus_stopped, [10:9] frame_status,
  // [11] heartbeat_refresh, [12] flush_fifo, [15:13] zero
  output logic [15:0]                   out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [crs_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]                    cfg_wdata
);

  // Configuration
  logic [7:0] err_limit_r;
  logic [7:0] stuck_limit_r;

  // Input register
  logic        s1_valid_r;
  logic [1:0]  cmd_r;
  logic [10:0] id_r;
  logic        ext_r;
  logic [3:0]  dlc_r;
  logic [63:0] pl_r;
  logic        bof_r;
  logic        ack_r;
  logic        fov_r;

  // Supervisor state
  crs_pkg::sup_t sup_r;
  crs_pkg::sup_t sup_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_state_r;
  logic       out_stopped_r;
  logic [1:0] out_status_r;
  logic       out_hb_r;
  logic       out_flush_r;

  logic       out_free;
  logic       advance;
  logic       in_fire;
  logic [7:0] sum;
  logic [7:0] alive;
  logic [1:0] status_nxt;
  logic       hb_nxt;
  logic       flush_nxt;

  // The result register is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Additive checksum over bytes 0..6, modulo 256
  assign sum = ((pl_r[7:0] + pl_r[15:8]) + (pl_r[23:16] + pl_r[31:24]))
             + ((pl_r[39:32] + pl_r[47:40]) + pl_r[55:48]);
  assign alive = pl_r[55:48];

  always_comb begin
    sup_nxt    = sup_r;
    status_nxt = crs_pkg::FS_IGNORED;
    hb_nxt     = 1'b0;
    flush_nxt  = 1'b0;
    case (cmd_r)
      crs_pkg::CMD_FRAME: begin
        // Drop frames while the bus is stopped and all extended frames
        if (!sup_r.bus_stopped && !ext_r) begin
          if (sum != pl_r[63:56]) begin
            sup_nxt    = crs_pkg::err_event(sup_r, id_r, 1'b0, err_limit_r);
            status_nxt = crs_pkg::FS_CHECKSUM;
          end else if (id_r == crs_pkg::ID_MOTOR_ERR || id_r == crs_pkg::ID_EMERGENCY ||
                       id_r == crs_pkg::ID_STATUS) begin
            if (alive == sup_r.last_alive) begin
              sup_nxt.stuck_cnt = crs_pkg::sat_inc(sup_r.stuck_cnt);
            end else begin
              sup_nxt.stuck_cnt  = 8'd0;
              sup_nxt.last_alive = alive;
            end
            if (alive == sup_r.last_alive && sup_nxt.stuck_cnt > stuck_limit_r) begin
              sup_nxt    = crs_pkg::err_event(sup_nxt, id_r, 1'b0, err_limit_r);
              status_nxt = crs_pkg::FS_STUCK;
            end else begin
              status_nxt = crs_pkg::FS_ACCEPTED;
              hb_nxt     = 1'b1;
              if (id_r == crs_pkg::ID_MOTOR_ERR) begin
                sup_nxt.node_state = crs_pkg::ST_MOTOR_ERR;
              end else if (id_r == crs_pkg::ID_EMERGENCY) begin
                sup_nxt.node_state = crs_pkg::ST_EMERGENCY;
              end else begin
                // Status frame: load state on full length, clear central errors
                if (dlc_r == 4'd8) begin
                  sup_nxt.node_state = pl_r[7:0];
                end
                sup_nxt.central_cnt = 8'd0;
              end
            end
          end
        end
      end
      crs_pkg::CMD_CTRL_ERR: begin
        if (bof_r) begin
          sup_nxt = crs_pkg::err_event(sup_nxt, crs_pkg::ID_HW, 1'b1, err_limit_r);
        end
        if (ack_r) begin
          sup_nxt.central_cnt = crs_pkg::sat_inc(sup_nxt.central_cnt);
        end
        flush_nxt = fov_r;
        // A report with no flag set is treated as a hardware error
        if (!bof_r && !ack_r && !fov_r) begin
          sup_nxt = crs_pkg::err_event(sup_nxt, crs_pkg::ID_HW, 1'b1, err_limit_r);
        end
      end
      crs_pkg::CMD_TX_FAIL: begin
        if (!sup_r.bus_stopped) begin
          sup_nxt = crs_pkg::err_event(sup_r, id_r, 1'b0, err_limit_r);
        end
      end
      default: begin
        sup_nxt = sup_r;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r   <= crs_pkg::ERROR_LIMIT_RST;
      stuck_limit_r <= crs_pkg::STUCK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        crs_pkg::CFG_ERROR_LIMIT: err_limit_r   <= cfg_wdata;
        crs_pkg::CFG_STUCK_LIMIT: stuck_limit_r <= cfg_wdata;
        default: begin
          err_limit_r <= err_limit_r;
        end
      endcase
    end
  end

  // Input register: load on accept, empty when the word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tuser;
      id_r  <= in_tdata[10:0];
      ext_r <= in_tdata[11];
      dlc_r <= in_tdata[15:12];
      pl_r  <= in_tdata[79:16];
      bof_r <= in_tdata[80];
      ack_r <= in_tdata[81];
      fov_r <= in_tdata[82];
    end
  end

  // Supervisor state: update as each word passes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r.node_state  <= crs_pkg::ST_OFF;
      sup_r.last_alive  <= 8'd0;
      sup_r.stuck_cnt   <= 8'd0;
      sup_r.central_cnt <= 8'd0;
      sup_r.local_cnt   <= 8'd0;
      sup_r.bus_stopped <= 1'b0;
    end else if (advance) begin
      sup_r <= sup_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r   <= sup_nxt.node_state;
      out_stopped_r <= sup_nxt.bus_stopped;
      out_status_r  <= status_nxt;
      out_hb_r      <= hb_nxt;
      out_flush_r   <= flush_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_flush_r, out_hb_r, out_status_r, out_stopped_r,
                       out_state_r};

  // Once stopped, the bus stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sup_r.bus_stopped |=> sup_r.bus_stopped)
    else $error("bus_stopped cleared without reset");

  // A reported stop is always reflected in the held state
  a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stopped_r) |-> sup_r.bus_stopped)
    else $error("result reports stop but state is running");

  // Heartbeat refresh only on an accepted frame
  a_hb_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hb_r) |-> (out_status_r == crs_pkg::FS_ACCEPTED))
    else $error("heartbeat refresh without accepted frame");

  // Flush only on a non-frame report, which always reads as ignored
  a_flush_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flush_r) |-> (out_status_r == crs_pkg::FS_IGNORED && !out_hb_r))
    else $error("flush request on a frame result");

  // A word in the input register is not lost while the result is stalled
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(pl_r) && $stable(cmd_r)))
    else $error("input register lost a word during stall");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CAN receive supervisor
// Streams received frames, controller error reports and transmit failure
// reports into the supervisor, predicts every status word from a local
// model of the node state and error counters, and compares each output
// word field by field. Limits are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;

  // The command code that the supervisor must treat as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int STALL_PCT  = 19;
  localparam int IDLE_LIMIT = 1000;   // cycles with no word moving on either side

  // One input word, split into its fields
  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] id;
    logic        ext;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic        bof;
    logic        ack;
    logic        fov;
  } can_word_t;

  // One status word as the supervisor should report it
  typedef struct packed {
    logic [7:0] node_state;
    logic       bus_stopped;
    logic [1:0] frame_status;
    logic       hb_refresh;
    logic       flush;
  } report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = crs_pkg::CMD_FRAME;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic [crs_pkg::CFG_IDX_W-1:0] cfg_addr = crs_pkg::CFG_ERROR_LIMIT;
  logic [7:0]  cfg_wdata  = '0;

  can_rx_supervisor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, the word on the bus, and the reports still due
  can_word_t rx_words[$];
  can_word_t cur_word;
  report_t   due_reports[$];

  // Bench copy of the supervisor state and its limits
  logic [7:0] lim_error   = crs_pkg::ERROR_LIMIT_RST;
  logic [7:0] lim_stuck   = crs_pkg::STUCK_LIMIT_RST;
  logic [7:0] sv_state    = crs_pkg::ST_OFF;
  logic [7:0] sv_alive    = 8'd0;
  logic [7:0] sv_stuck    = 8'd0;
  logic [7:0] sv_central  = 8'd0;
  logic [7:0] sv_local    = 8'd0;
  logic       sv_stopped  = 1'b0;

  // Stimulus shaping: quiet turns idling off, tx_hold parks the sender
  bit         quiet   = 1'b0;
  bit         tx_hold = 1'b0;
  logic [7:0] alive_seq   = 8'h80;
  int         repeat_left = 0;

  int n_in = 0;
  int n_out = 0;
  int n_fail = 0;
  int idle_cycles = 0;
  int fs_tally[4] = '{0, 0, 0, 0};
  bit saw_central_down = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Charge one error event to an ID group; hw marks a controller fault
  task automatic count_fault(input logic [10:0] id, input bit hw);
    if (id == crs_pkg::ID_LOCAL_A || id == crs_pkg::ID_LOCAL_B) begin
      sv_local = bump(sv_local);
      if (sv_local >= lim_error) begin
        sv_stopped = 1'b1;
        sv_state   = crs_pkg::ST_BROKEN;
      end
    end else if (id == crs_pkg::ID_STATUS) begin
      sv_central = bump(sv_central);
      if (sv_central >= lim_error) begin
        sv_state = crs_pkg::ST_CENTRAL_DOWN;
        saw_central_down = 1'b1;
      end
    end else if (id == crs_pkg::ID_HW && hw) begin
      sv_stopped = 1'b1;
      sv_state   = crs_pkg::ST_BROKEN;
    end
  endtask

  // Advance the bench state by one accepted word and queue its report
  task automatic supervise(input can_word_t w);
    report_t    r;
    logic [7:0] sum;
    logic [7:0] alive;
    bit         stuck;
    r.frame_status = crs_pkg::FS_IGNORED;
    r.hb_refresh   = 1'b0;
    r.flush        = 1'b0;
    case (w.cmd)
      crs_pkg::CMD_FRAME: begin
        if (!sv_stopped && !w.ext) begin
          sum = 8'd0;
          for (int i = 0; i < 7; i++) sum = sum + w.payload[8*i +: 8];
          if (sum != w.payload[63:56]) begin
            count_fault(w.id, 1'b0);
            r.frame_status = crs_pkg::FS_CHECKSUM;
          end else if (w.id == crs_pkg::ID_MOTOR_ERR || w.id == crs_pkg::ID_EMERGENCY ||
                       w.id == crs_pkg::ID_STATUS) begin
            alive = w.payload[55:48];
            stuck = 1'b0;
            if (alive == sv_alive) begin
              sv_stuck = bump(sv_stuck);
              stuck = (sv_stuck > lim_stuck);
            end else begin
              sv_stuck = 8'd0;
              sv_alive = alive;
            end
            if (stuck) begin
              count_fault(w.id, 1'b0);
              r.frame_status = crs_pkg::FS_STUCK;
            end else begin
              r.frame_status = crs_pkg::FS_ACCEPTED;
              r.hb_refresh   = 1'b1;
              if (w.id == crs_pkg::ID_MOTOR_ERR) begin
                sv_state = crs_pkg::ST_MOTOR_ERR;
              end else if (w.id == crs_pkg::ID_EMERGENCY) begin
                sv_state = crs_pkg::ST_EMERGENCY;
              end else begin
                // status frame: load state only on a full eight-byte frame
                if (w.dlc == 4'd8) sv_state = w.payload[7:0];
                sv_central = 8'd0;
              end
            end
          end
        end
      end
      crs_pkg::CMD_CTRL_ERR: begin
        if (w.bof) count_fault(crs_pkg::ID_HW, 1'b1);
        if (w.ack) sv_central = bump(sv_central);
        if (w.fov) r.flush = 1'b1;
        // a report with no flag set counts as an unclassified fault
        if (!w.bof && !w.ack && !w.fov) count_fault(crs_pkg::ID_HW, 1'b1);
      end
      crs_pkg::CMD_TX_FAIL: begin
        if (!sv_stopped) count_fault(w.id, 1'b0);
      end
      default: ;
    endcase
    r.node_state  = sv_state;
    r.bus_stopped = sv_stopped;
    fs_tally[r.frame_status]++;
    due_reports.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  // Frame whose byte 7 is the sum of bytes 0..6 of body
  function automatic can_word_t frame_word(input logic [10:0] id, input logic ext,
                                           input logic [3:0] dlc,
                                           input logic [63:0] body);
    can_word_t  w;
    logic [7:0] sum;
    sum = 8'd0;
    for (int i = 0; i < 7; i++) sum = sum + body[8*i +: 8];
    w.cmd     = crs_pkg::CMD_FRAME;
    w.id      = id;
    w.ext     = ext;
    w.dlc     = dlc;
    w.payload = {sum, body[55:0]};
    w.bof     = 1'b0;
    w.ack     = 1'b0;
    w.fov     = 1'b0;
    return w;
  endfunction

  function automatic can_word_t good_frame(input logic [10:0] id, input logic [7:0] alive,
                                           input logic [3:0] dlc, input logic [7:0] b0);
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    return frame_word(id, 1'b0, dlc, {8'h00, alive, rnd[47:8], b0});
  endfunction

  function automatic can_word_t bad_frame(input logic [10:0] id);
    can_word_t  w;
    logic [7:0] flip;
    w = good_frame(id, 8'($urandom), 4'($urandom_range(0, 8)), 8'($urandom));
    flip = 8'($urandom_range(1, 255));
    w.payload[63:56] = w.payload[63:56] ^ flip;
    return w;
  endfunction

  // Non-frame word; the frame fields carry random noise
  function automatic can_word_t event_word(input logic [1:0] cmd, input logic [10:0] id,
                                           input logic bof, input logic ack,
                                           input logic fov);
    can_word_t w;
    w.cmd     = cmd;
    w.id      = id;
    w.ext     = 1'($urandom_range(0, 1));
    w.dlc     = 4'($urandom_range(0, 8));
    w.payload = {$urandom, $urandom};
    w.bof     = bof;
    w.ack     = ack;
    w.fov     = fov;
    return w;
  endfunction

  // ID for an error-producing word; without local IDs the bus cannot stop
  function automatic logic [10:0] fault_id(input bit with_local);
    logic [10:0] id;
    case ($urandom_range(0, 4))
      0: id = crs_pkg::ID_STATUS;
      1: id = with_local ? crs_pkg::ID_LOCAL_A : crs_pkg::ID_MOTOR_ERR;
      2: id = with_local ? crs_pkg::ID_LOCAL_B : crs_pkg::ID_EMERGENCY;
      3: id = crs_pkg::ID_HW;
      default: begin
        id = 11'($urandom_range(0, 2047));
        if (!with_local && (id == crs_pkg::ID_LOCAL_A || id == crs_pkg::ID_LOCAL_B))
          id = crs_pkg::ID_STATUS;
      end
    endcase
    return id;
  endfunction

  // Mostly well-formed supervised frames with alive runs, plus faults and noise
  task automatic queue_random(input int count, input bit with_local);
    int          pick;
    logic [10:0] id;
    logic [7:0]  b0;
    logic [3:0]  dlc;
    logic        ack;
    logic        fov;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // hold the alive counter for a run of repeats, else step it
        if (repeat_left > 0) repeat_left--;
        else if ($urandom_range(0, 4) == 0) repeat_left = $urandom_range(1, 8);
        else alive_seq = alive_seq + 8'($urandom_range(1, 3));
        case ($urandom_range(0, 3))
          0: id = crs_pkg::ID_MOTOR_ERR;
          1: id = crs_pkg::ID_EMERGENCY;
          default: id = crs_pkg::ID_STATUS;
        endcase
        b0  = $urandom_range(0, 1) ? (8'h01 << $urandom_range(0, 6)) : 8'($urandom);
        dlc = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(0, 8));
        rx_words.push_back(good_frame(id, alive_seq, dlc, b0));
      end else if (pick < 63) begin
        rx_words.push_back(bad_frame(fault_id(with_local)));
      end else if (pick < 71) begin
        id = 11'($urandom_range(0, 2047));
        if (!with_local && (id == crs_pkg::ID_LOCAL_A || id == crs_pkg::ID_LOCAL_B))
          id = crs_pkg::ID_HW;
        rx_words.push_back(frame_word(id, 1'($urandom_range(0, 1)),
                                      4'($urandom_range(0, 8)), {$urandom, $urandom}));
      end else if (pick < 81) begin
        rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, fault_id(with_local),
                                      1'b0, 1'b0, 1'b0));
      end else begin
        // keep bus-off and empty reports out: they stop the bus for good
        ack = 1'($urandom_range(0, 1));
        fov = 1'($urandom_range(0, 1));
        if (!ack && !fov) ack = 1'b1;
        rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, 11'($urandom_range(0, 2047)),
                                      1'b0, ack, fov));
      end
    end
  endtask

  // Once the bus is down anything goes
  task automatic queue_stopped(input int count);
    logic [1:0] cmd;
    for (int k = 0; k < count; k++) begin
      cmd = 2'($urandom_range(0, 2));
      if (cmd == crs_pkg::CMD_FRAME)
        rx_words.push_back(good_frame(11'($urandom_range(0, 4)), 8'($urandom),
                                      4'($urandom_range(0, 8)), 8'($urandom)));
      else
        rx_words.push_back(event_word(cmd, 11'($urandom_range(0, 2047)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  // Wait until nothing is queued, on the bus or still due
  task automatic wait_drained();
    while (rx_words.size() > 0 || in_tvalid || due_reports.size() > 0) @(negedge clk);
  endtask

  // Write one limit register while the block is idle
  task automatic write_limit(input logic [crs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == crs_pkg::CFG_ERROR_LIMIT) lim_error = val;
    else lim_stuck = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next queued word, hold it until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    can_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        supervise(cur_word);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (rx_words.size() > 0 && !tx_hold &&
            (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
          nxt = rx_words.pop_front();
          cur_word  <= nxt;
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.cmd;
          in_tdata  <= {5'd0, nxt.fov, nxt.ack, nxt.bof, nxt.payload, nxt.dlc,
                        nxt.ext, nxt.id};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each status word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    report_t r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (due_reports.size() == 0) begin
          n_fail++;
          $error("status word 0x%04h with nothing due", out_tdata);
        end else begin
          r = due_reports.pop_front();
          if (out_tdata[7:0] !== r.node_state) begin
            n_fail++;
            $error("node_state: expected 0x%02h, got 0x%02h", r.node_state, out_tdata[7:0]);
          end
          if (out_tdata[8] !== r.bus_stopped) begin
            n_fail++;
            $error("bus_stopped: expected %0b, got %0b", r.bus_stopped, out_tdata[8]);
          end
          if (out_tdata[10:9] !== r.frame_status) begin
            n_fail++;
            $error("frame_status: expected %0d, got %0d", r.frame_status, out_tdata[10:9]);
          end
          if (out_tdata[11] !== r.hb_refresh) begin
            n_fail++;
            $error("heartbeat_refresh: expected %0b, got %0b", r.hb_refresh, out_tdata[11]);
          end
          if (out_tdata[12] !== r.flush) begin
            n_fail++;
            $error("flush_fifo: expected %0b, got %0b", r.flush, out_tdata[12]);
          end
        end
      end
      out_tready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Watchdog: give up when no word moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("can_rx_supervisor: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset limits
    rx_words.push_back(frame_word(crs_pkg::ID_MOTOR_ERR, 1'b0, 4'd8, 64'h0)); // alive repeats 0
    rx_words.push_back(frame_word(crs_pkg::ID_HW, 1'b1, 4'd8, {64{1'b1}}));   // extended: ignore
    rx_words.push_back(frame_word(crs_pkg::ID_HW, 1'b0, 4'd0, {64{1'b1}}));   // unknown ID
    rx_words.push_back(good_frame(crs_pkg::ID_EMERGENCY, 8'h11, 4'd8, 8'h00));
    rx_words.push_back(good_frame(crs_pkg::ID_STATUS, 8'h12, 4'd8, 8'h04));   // load drive
    rx_words.push_back(good_frame(crs_pkg::ID_STATUS, 8'h13, 4'd7, 8'h02));   // short: keep
    rx_words.push_back(good_frame(crs_pkg::ID_STATUS, 8'h14, 4'd15, 8'h02));  // over-long: keep
    rx_words.push_back(good_frame(crs_pkg::ID_STATUS, 8'h15, 4'd8, 8'hFF));
    rx_words.push_back(bad_frame(crs_pkg::ID_STATUS));
    rx_words.push_back(bad_frame(crs_pkg::ID_LOCAL_A));
    rx_words.push_back(good_frame(crs_pkg::ID_LOCAL_B, 8'h16, 4'd8, 8'h00));  // unsupervised
    rx_words.push_back(event_word(CMD_UNUSED, crs_pkg::ID_STATUS, 1'b1, 1'b1, 1'b1));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_LOCAL_A,
                                  1'b0, 1'b1, 1'b0));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_HW, 1'b0, 1'b0, 1'b1));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_STATUS,
                                  1'b0, 1'b1, 1'b1));
    rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, crs_pkg::ID_LOCAL_B,
                                  1'b0, 1'b0, 1'b0));
    // never a hw fault
    rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, crs_pkg::ID_HW, 1'b0, 1'b0, 1'b0));
    rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, crs_pkg::ID_STATUS,
                                  1'b0, 1'b0, 1'b0));
    // one fresh alive value, then repeats until the sixth is judged stuck
    for (int k = 0; k < 7; k++)
      rx_words.push_back(good_frame(crs_pkg::ID_STATUS, 8'h5A, 4'd8, crs_pkg::ST_OFF));

    // Every repeat stuck; errors counted up to the top limit
    write_limit(crs_pkg::CFG_ERROR_LIMIT, 8'd255);
    write_limit(crs_pkg::CFG_STUCK_LIMIT, 8'd0);
    @(negedge clk);
    queue_random(200, 1'b1);

    // Low error limit: drive central down, keep local faults out; run most of it
    // with no idling on either side
    write_limit(crs_pkg::CFG_ERROR_LIMIT, 8'd3);
    write_limit(crs_pkg::CFG_STUCK_LIMIT, 8'd254);
    @(negedge clk);
    quiet = 1'b1;
    queue_random(200, 1'b0);
    while (rx_words.size() > 60) @(negedge clk);
    quiet = 1'b0;

    // Middle settings; park the sender once until every report is back
    write_limit(crs_pkg::CFG_ERROR_LIMIT, 8'd255);
    write_limit(crs_pkg::CFG_STUCK_LIMIT, 8'd2);
    @(negedge clk);
    queue_random(200, 1'b1);
    while (rx_words.size() > 100) @(negedge clk);
    tx_hold = 1'b1;
    while (in_tvalid || due_reports.size() > 0) @(negedge clk);
    tx_hold = 1'b0;

    // Limit of one: the next local fault stops the bus; then check that a
    // stopped bus drops frames and transmit failures but still counts
    // controller reports
    write_limit(crs_pkg::CFG_ERROR_LIMIT, 8'd1);
    write_limit(crs_pkg::CFG_STUCK_LIMIT, crs_pkg::STUCK_LIMIT_RST);
    @(negedge clk);
    rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, crs_pkg::ID_LOCAL_B,
                                  1'b0, 1'b0, 1'b0));
    rx_words.push_back(good_frame(crs_pkg::ID_EMERGENCY, 8'h77, 4'd8, 8'h00));
    rx_words.push_back(bad_frame(crs_pkg::ID_STATUS));
    rx_words.push_back(event_word(crs_pkg::CMD_TX_FAIL, crs_pkg::ID_STATUS,
                                  1'b0, 1'b0, 1'b0));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_STATUS,
                                  1'b1, 1'b0, 1'b0));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_STATUS,
                                  1'b0, 1'b0, 1'b0));
    rx_words.push_back(event_word(crs_pkg::CMD_CTRL_ERR, crs_pkg::ID_LOCAL_A,
                                  1'b1, 1'b1, 1'b1));
    queue_stopped(150);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d words over five limit settings: %0d accepted, %0d checksum, %0d stuck",
             n_in, fs_tally[crs_pkg::FS_ACCEPTED], fs_tally[crs_pkg::FS_CHECKSUM],
             fs_tally[crs_pkg::FS_STUCK]);
    $display("  %0d ignored, %0d status words checked, central down seen: %0b, bus stopped: %0b",
             fs_tally[crs_pkg::FS_IGNORED], n_out, saw_central_down, sv_stopped);
    if (n_fail == 0) begin
      $display("can_rx_supervisor: match");
    end else begin
      $display("can_rx_supervisor: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/crs_pkg.sv
design/can_rx_supervisor.sv
tb/tb_top.sv
